@@ hdl/rbep_pkg.sv @@
package rbep_pkg;

  localparam int unsigned CountW = 8;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CountW-1:0] CountMax = '1;

  // register indexes on the configuration port
  localparam logic [CfgAddrW-1:0] REG_FAILS_PER_RESTART   = 2'd0;
  localparam logic [CfgAddrW-1:0] REG_RESTARTS_PER_REBOOT = 2'd1;
  localparam logic [CfgAddrW-1:0] REG_BASE_DELAY          = 2'd2;
  localparam logic [CfgAddrW-1:0] REG_MAX_DELAY           = 2'd3;

  localparam logic [CountW-1:0] FailsPerRestartRst   = 8'd3;
  localparam logic [CountW-1:0] RestartsPerRebootRst = 8'd2;
  localparam logic [TimeW-1:0]  BaseDelayRst         = 32'd1000;
  localparam logic [TimeW-1:0]  MaxDelayRst          = 32'd60000;

  typedef enum logic [1:0] {
    MODE_POLL         = 2'd0,
    MODE_CONNECTED    = 2'd1,
    MODE_FAILED       = 2'd2,
    MODE_DISCONNECTED = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_CONNECT = 2'd1,
    ACT_RESTART = 2'd2,
    ACT_REBOOT  = 2'd3
  } action_e;

  typedef struct packed {
    logic [CountW-1:0] fails_per_restart;
    logic [CountW-1:0] restarts_per_reboot;
    logic [TimeW-1:0]  base_delay;
    logic [TimeW-1:0]  max_delay;
  } cfg_t;

endpackage

@@ hdl/rbep_cfg.sv @@
module rbep_cfg
  import rbep_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_FAILS_PER_RESTART:   cfg_d.fails_per_restart   = cfg_wdata_i[CountW-1:0];
        REG_RESTARTS_PER_REBOOT: cfg_d.restarts_per_reboot = cfg_wdata_i[CountW-1:0];
        REG_BASE_DELAY:          cfg_d.base_delay          = cfg_wdata_i[TimeW-1:0];
        REG_MAX_DELAY:           cfg_d.max_delay           = cfg_wdata_i[TimeW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fails_per_restart   <= FailsPerRestartRst;
      cfg_q.restarts_per_reboot <= RestartsPerRebootRst;
      cfg_q.base_delay          <= BaseDelayRst;
      cfg_q.max_delay           <= MaxDelayRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hdl/rbep_core.sv @@
module rbep_core
  import rbep_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  mode_e            mode_i,
  input  logic [TimeW-1:0] now_time_i,
  input  cfg_t             cfg_i,
  output action_e          action_o
);

  logic              reboot_q, reboot_d;
  logic              link_up_q, link_up_d;
  logic              busy_q, busy_d;
  logic              dl_valid_q, dl_valid_d;
  logic [CountW-1:0] fail_cnt_q, fail_cnt_d;
  logic [CountW-1:0] rst_cnt_q, rst_cnt_d;
  logic [TimeW-1:0]  delay_q, delay_d;
  logic [TimeW-1:0]  next_time_q, next_time_d;
  logic [TimeW-1:0]  att_time_q, att_time_d;

  logic [TimeW-1:0]  diff;
  logic [TimeW:0]    doubled;
  logic [TimeW-1:0]  new_delay;
  logic [CountW-1:0] rst_cnt_inc;
  action_e           action;

  assign diff        = now_time_i - next_time_q;
  assign doubled     = {delay_q, 1'b0};
  assign rst_cnt_inc = (rst_cnt_q != CountMax) ? rst_cnt_q + 1'b1 : rst_cnt_q;

  // first failure loads the base uncapped; later ones double up to the ceiling
  always_comb begin
    if (delay_q == '0) begin
      new_delay = cfg_i.base_delay;
    end else if (doubled > {1'b0, cfg_i.max_delay}) begin
      new_delay = cfg_i.max_delay;
    end else begin
      new_delay = doubled[TimeW-1:0];
    end
  end

  always_comb begin
    reboot_d    = reboot_q;
    link_up_d   = link_up_q;
    busy_d      = busy_q;
    dl_valid_d  = dl_valid_q;
    fail_cnt_d  = fail_cnt_q;
    rst_cnt_d   = rst_cnt_q;
    delay_d     = delay_q;
    next_time_d = next_time_q;
    att_time_d  = att_time_q;
    action      = ACT_NONE;
    unique case (mode_i)
      MODE_POLL: begin
        if (reboot_q) begin
          action = ACT_REBOOT;
        end else if (link_up_q || busy_q) begin
          action = ACT_NONE;
        end else if (dl_valid_q && diff[TimeW-1]) begin
          action = ACT_NONE;
        end else if (fail_cnt_q >= cfg_i.fails_per_restart) begin
          fail_cnt_d  = '0;
          rst_cnt_d   = rst_cnt_inc;
          delay_d     = '0;
          next_time_d = '0;
          dl_valid_d  = 1'b0;
          if (rst_cnt_inc > cfg_i.restarts_per_reboot) begin
            reboot_d = 1'b1;
            action   = ACT_REBOOT;
          end else begin
            action = ACT_RESTART;
          end
        end else begin
          busy_d     = 1'b1;
          att_time_d = now_time_i;
          action     = ACT_CONNECT;
        end
      end
      MODE_CONNECTED: begin
        link_up_d   = 1'b1;
        busy_d      = 1'b0;
        reboot_d    = 1'b0;
        dl_valid_d  = 1'b0;
        fail_cnt_d  = '0;
        rst_cnt_d   = '0;
        delay_d     = '0;
        next_time_d = '0;
      end
      MODE_FAILED: begin
        busy_d      = 1'b0;
        fail_cnt_d  = (fail_cnt_q != CountMax) ? fail_cnt_q + 1'b1 : fail_cnt_q;
        delay_d     = new_delay;
        next_time_d = att_time_q + new_delay;
        dl_valid_d  = 1'b1;
      end
      MODE_DISCONNECTED: begin
        link_up_d   = 1'b0;
        busy_d      = 1'b0;
        dl_valid_d  = 1'b0;
        fail_cnt_d  = '0;
        delay_d     = '0;
        next_time_d = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reboot_q    <= 1'b0;
      link_up_q   <= 1'b0;
      busy_q      <= 1'b0;
      dl_valid_q  <= 1'b0;
      fail_cnt_q  <= '0;
      rst_cnt_q   <= '0;
      delay_q     <= '0;
      next_time_q <= '0;
      att_time_q  <= '0;
    end else if (step_i) begin
      reboot_q    <= reboot_d;
      link_up_q   <= link_up_d;
      busy_q      <= busy_d;
      dl_valid_q  <= dl_valid_d;
      fail_cnt_q  <= fail_cnt_d;
      rst_cnt_q   <= rst_cnt_d;
      delay_q     <= delay_d;
      next_time_q <= next_time_d;
      att_time_q  <= att_time_d;
    end
  end

  assign action_o = action;

endmodule

@@ hdl/retry_backoff_escalation_policy.sv @@
// Link recovery policy with capped exponential backoff.
// Input stream s_axis carries one event per transaction: mode in tdata[1:0]
// (poll, connected, connect failed, disconnected) and the millisecond time
// in tdata[33:2]. Every event gives exactly one output transaction on
// m_axis with the action in tdata[1:0]; non-poll events answer none.
// Configuration is a plain write port (cfg_we_i, cfg_addr_i, cfg_wdata_i),
// to be used only while no event is in flight.
// The input register takes the event, then the policy update runs from it
// into the result register, which drives m_axis_tvalid and m_axis_tdata.
// Throughput is one event per cycle while m_axis_tready stays high; the
// state update is a single pass of compares, a 33-bit doubling/cap and a
// 32-bit add between the registers.
// When the receiver stalls, the result register holds and the input
// register can still take one more event; s_axis_tready drops only while
// both hold data and m_axis_tready is low.
// Reset clears all policy state and both valids, and loads the default
// thresholds (3 failures, 2 restarts, 1000 ms base, 60000 ms ceiling).
module retry_backoff_escalation_policy
  import rbep_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [39:0]         s_axis_tdata,  // [1:0] mode, [33:2] now_time
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,  // [1:0] action
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t             cfg;
  logic             in_valid_q;
  mode_e            in_mode_q;
  logic [TimeW-1:0] in_time_q;
  logic             out_valid_q;
  action_e          out_action_q;
  action_e          action;
  logic             advance;
  logic             step;

  assign advance       = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_mode_q <= mode_e'(s_axis_tdata[1:0]);
      in_time_q <= s_axis_tdata[33:2];
    end
    if (step) begin
      out_action_q <= action;
    end
  end

  rbep_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  rbep_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .mode_i     (in_mode_q),
    .now_time_i (in_time_q),
    .cfg_i      (cfg),
    .action_o   (action)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_action_q};

endmodule

@@ hdl/rbep_checker.sv @@
module rbep_sva
  import rbep_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [39:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // input side only backs up when the output is full and stalled
  a_ready_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[7:2] == 6'd0)
    else $error("padding bits of result not zero");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

  // a non-poll event accepted while the output stays free answers none
  a_nonpoll_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid
      && (s_axis_tdata[1:0] == MODE_CONNECTED || s_axis_tdata[1:0] == MODE_FAILED
          || s_axis_tdata[1:0] == MODE_DISCONNECTED)
      ##1 !m_axis_tvalid
    |=> m_axis_tvalid && m_axis_tdata[1:0] == ACT_NONE)
    else $error("non-poll event gave an action");

endmodule

bind retry_backoff_escalation_policy rbep_sva u_checker (.*);

@@ test/rbep_checker.sv @@
`timescale 1ns / 100ps

module rbep_checker
  import rbep_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                ev_valid_i,
  input  logic                ev_ready_i,
  input  logic [39:0]         ev_data_i,
  input  logic                act_valid_i,
  input  logic                act_ready_i,
  input  logic [7:0]          act_data_i,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output int unsigned         errors_o,
  output int unsigned         pending_o,
  output int unsigned         checked_o,
  output int unsigned         restarts_o,
  output int unsigned         reboots_o
);

  // thresholds as last written
  logic [CountW-1:0] cfg_fails;
  logic [CountW-1:0] cfg_restarts;
  logic [TimeW-1:0]  cfg_base;
  logic [TimeW-1:0]  cfg_max;

  // predicted policy state
  logic              p_reboot;
  logic              p_link;
  logic              p_busy;
  logic              p_dl_valid;
  logic [CountW-1:0] p_fails;
  logic [CountW-1:0] p_restarts;
  logic [TimeW-1:0]  p_delay;
  logic [TimeW-1:0]  p_next;
  logic [TimeW-1:0]  p_attempt;

  action_e     action_q[$];
  int unsigned n_err;
  int unsigned n_chk;
  int unsigned n_rst;
  int unsigned n_rbt;

  function automatic action_e next_action(input mode_e m, input logic [TimeW-1:0] t);
    logic [TimeW:0]   dbl;
    logic [TimeW-1:0] diff;
    action_e          a;
    a = ACT_NONE;
    case (m)
      MODE_POLL: begin
        diff = t - p_next;
        if (p_reboot) begin
          a = ACT_REBOOT;
        end else if (p_link || p_busy) begin
          a = ACT_NONE;
        end else if (p_dl_valid && diff[TimeW-1]) begin
          a = ACT_NONE;  // deadline still ahead, wrap-safe
        end else if (p_fails >= cfg_fails) begin
          p_fails = '0;
          if (p_restarts != CountMax) p_restarts = p_restarts + 1'b1;
          p_delay    = '0;
          p_next     = '0;
          p_dl_valid = 1'b0;
          if (p_restarts > cfg_restarts) begin
            p_reboot = 1'b1;
            a = ACT_REBOOT;
          end else begin
            a = ACT_RESTART;
          end
        end else begin
          p_busy    = 1'b1;
          p_attempt = t;
          a = ACT_CONNECT;
        end
      end
      MODE_CONNECTED: begin
        p_link     = 1'b1;
        p_busy     = 1'b0;
        p_reboot   = 1'b0;
        p_dl_valid = 1'b0;
        p_fails    = '0;
        p_restarts = '0;
        p_delay    = '0;
        p_next     = '0;
      end
      MODE_FAILED: begin
        p_busy = 1'b0;
        if (p_fails != CountMax) p_fails = p_fails + 1'b1;
        if (p_delay == '0) begin
          p_delay = cfg_base;  // first failure: base, not capped
        end else begin
          dbl = {p_delay, 1'b0};
          if (dbl > {1'b0, cfg_max}) p_delay = cfg_max;
          else p_delay = dbl[TimeW-1:0];
        end
        p_next     = p_attempt + p_delay;
        p_dl_valid = 1'b1;
      end
      default: begin
        p_link     = 1'b0;
        p_busy     = 1'b0;
        p_dl_valid = 1'b0;
        p_fails    = '0;
        p_delay    = '0;
        p_next     = '0;
      end
    endcase
    return a;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_fails    = FailsPerRestartRst;
      cfg_restarts = RestartsPerRebootRst;
      cfg_base     = BaseDelayRst;
      cfg_max      = MaxDelayRst;
      p_reboot     = 1'b0;
      p_link       = 1'b0;
      p_busy       = 1'b0;
      p_dl_valid   = 1'b0;
      p_fails      = '0;
      p_restarts   = '0;
      p_delay      = '0;
      p_next       = '0;
      p_attempt    = '0;
      action_q.delete();
      n_err = 0;
      n_chk = 0;
      n_rst = 0;
      n_rbt = 0;
      errors_o   <= 0;
      pending_o  <= 0;
      checked_o  <= 0;
      restarts_o <= 0;
      reboots_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_FAILS_PER_RESTART:   cfg_fails    = cfg_wdata_i[CountW-1:0];
          REG_RESTARTS_PER_REBOOT: cfg_restarts = cfg_wdata_i[CountW-1:0];
          REG_BASE_DELAY:          cfg_base     = cfg_wdata_i;
          REG_MAX_DELAY:           cfg_max      = cfg_wdata_i;
          default: ;
        endcase
      end
      // result side first: an expectation pushed this edge cannot be answered yet
      if (act_valid_i && act_ready_i) begin
        if (action_q.size() == 0) begin
          if (n_err < 10)
            $display("unexpected action %0d with no event outstanding", act_data_i[1:0]);
          n_err++;
        end else begin
          if (act_data_i[1:0] !== action_q[0]) begin
            if (n_err < 10)
              $display("action mismatch on result %0d: expected %s (%0d), got %0d",
                       n_chk, action_q[0].name(), action_q[0], act_data_i[1:0]);
            n_err++;
          end
          if (action_q[0] == ACT_RESTART) n_rst++;
          if (action_q[0] == ACT_REBOOT) n_rbt++;
          void'(action_q.pop_front());
          n_chk++;
        end
      end
      if (ev_valid_i && ev_ready_i)
        action_q.push_back(next_action(mode_e'(ev_data_i[1:0]), ev_data_i[33:2]));
      errors_o   <= n_err;
      pending_o  <= action_q.size();
      checked_o  <= n_chk;
      restarts_o <= n_rst;
      reboots_o  <= n_rbt;
    end
  end

endmodule

@@ test/retry_backoff_escalation_policy_tb.sv @@
`timescale 1ns / 100ps

module retry_backoff_escalation_policy_tb;
  import rbep_pkg::*;

  localparam int unsigned QuietLimit = 2000;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [39:0]         s_axis_tdata;   // [1:0] mode, [33:2] now_time
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [7:0]          m_axis_tdata;   // [1:0] action
  logic                cfg_we_i;
  logic [CfgAddrW-1:0] cfg_addr_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  int unsigned errors;
  int unsigned pending;
  int unsigned checked;
  int unsigned restarts_seen;
  int unsigned reboots_seen;

  int unsigned      events_sent;
  int unsigned      accepted_cnt;
  int unsigned      send_idle_pct;
  int unsigned      recv_idle_pct;
  logic [TimeW-1:0] now_ms;

  retry_backoff_escalation_policy uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  rbep_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ev_valid_i  (s_axis_tvalid),
    .ev_ready_i  (s_axis_tready),
    .ev_data_i   (s_axis_tdata),
    .act_valid_i (m_axis_tvalid),
    .act_ready_i (m_axis_tready),
    .act_data_i  (m_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .errors_o    (errors),
    .pending_o   (pending),
    .checked_o   (checked),
    .restarts_o  (restarts_seen),
    .reboots_o   (reboots_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) accepted_cnt <= 0;
    else if (s_axis_tvalid && s_axis_tready) accepted_cnt <= accepted_cnt + 1;
  end

  // receiver: random stalls, plus one long hold-off while events keep coming
  initial begin
    int unsigned hold_left;
    bit          held;
    hold_left = 0;
    held      = 1'b0;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && accepted_cnt >= 900) begin
        held      = 1'b1;
        hold_left = 80;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
             QuietLimit, pending);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic set_profile(input int unsigned snd, input int unsigned rcv);
    send_idle_pct = snd;
    recv_idle_pct <= rcv;
  endtask

  task automatic send_event(input mode_e m, input logic [TimeW-1:0] t);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, t, m};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    events_sent++;
  endtask

  task automatic advance_clock();
    case ($urandom_range(0, 9))
      0: ;
      1, 2, 3, 4, 5: now_ms = now_ms + $urandom_range(0, 1500);
      6, 7: now_ms = now_ms + $urandom_range(0, 70000);
      default: now_ms = $urandom;
    endcase
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [CountW-1:0] fails, input logic [CountW-1:0] rsts,
                           input logic [TimeW-1:0] base, input logic [TimeW-1:0] cap);
    wait_idle();
    write_reg(REG_FAILS_PER_RESTART, {24'd0, fails});
    write_reg(REG_RESTARTS_PER_REBOOT, {24'd0, rsts});
    write_reg(REG_BASE_DELAY, base);
    write_reg(REG_MAX_DELAY, cap);
    cfg_we_i <= 1'b0;
  endtask

  // under the reset thresholds: 3 failures, 2 restarts, 1000 ms base
  task automatic directed();
    send_event(MODE_POLL, 32'd0);               // connect, attempt at 0
    send_event(MODE_POLL, 32'hFFFF_FFFF);       // attempt busy
    send_event(MODE_FAILED, 32'd0);             // deadline 1000
    send_event(MODE_POLL, 32'd999);             // pending
    send_event(MODE_POLL, 32'd1000);            // deadline reached exactly
    send_event(MODE_FAILED, 32'hFFFF_FFFF);     // doubled to 2000
    send_event(MODE_FAILED, 32'd0);             // failure with no attempt running
    send_event(MODE_POLL, 32'd4999);
    send_event(MODE_POLL, 32'd5000);            // third failure: restart
    send_event(MODE_POLL, 32'd5001);
    send_event(MODE_CONNECTED, 32'd0);
    send_event(MODE_POLL, 32'hFFFF_FFFF);       // link up
    send_event(MODE_DISCONNECTED, 32'hFFFF_FFFF);
    send_event(MODE_POLL, 32'hFFFF_FF00);
    send_event(MODE_FAILED, 32'd0);             // deadline wraps past zero
    send_event(MODE_POLL, 32'h0000_0100);
    send_event(MODE_POLL, 32'h0000_02E8);
    send_event(MODE_FAILED, 32'd0);
    send_event(MODE_FAILED, 32'd0);
    send_event(MODE_POLL, 32'h7FFF_FFFF);
    send_event(MODE_POLL, 32'h8000_0000);
  endtask

  task automatic saturate(input mode_e m);
    int unsigned k;
    send_event(MODE_CONNECTED, now_ms);
    send_event(MODE_DISCONNECTED, now_ms);
    for (k = 0; k < 260; k++) begin
      advance_clock();
      send_event(m, now_ms);
    end
  endtask

  task automatic run_random(input int unsigned n);
    int unsigned target;
    int unsigned pick;
    int unsigned k;
    int unsigned reps;
    target = events_sent + n;
    while (events_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        // one connection attempt and its outcome
        advance_clock();
        send_event(MODE_POLL, now_ms);
        reps = $urandom_range(0, 2);
        for (k = 0; k < reps; k++) begin
          now_ms = now_ms + $urandom_range(0, 500);
          send_event(MODE_POLL, now_ms);
        end
        pick = $urandom_range(0, 99);
        if (pick < 85) begin
          send_event(MODE_FAILED, $urandom);
        end else if (pick < 95) begin
          send_event(MODE_CONNECTED, $urandom);
          reps = $urandom_range(0, 3);
          for (k = 0; k < reps; k++) begin
            advance_clock();
            send_event(MODE_POLL, now_ms);
          end
          send_event(MODE_DISCONNECTED, $urandom);
        end
      end else if (pick < 80) begin
        reps = $urandom_range(1, 4);
        for (k = 0; k < reps; k++) begin
          advance_clock();
          send_event(MODE_POLL, now_ms);
        end
      end else if (pick < 88) begin
        reps = $urandom_range(1, 3);
        for (k = 0; k < reps; k++) send_event(MODE_FAILED, $urandom);
      end else if (pick < 92) begin
        send_event(MODE_DISCONNECTED, $urandom);
      end else begin
        send_event(mode_e'($urandom_range(0, 3)), $urandom);
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_addr_i    <= '0;
    cfg_wdata_i   <= '0;
    events_sent   = 0;
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    now_ms        = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_profile(18, 49);
    directed();
    now_ms = $urandom;
    run_random(100);

    configure(8'd0, 8'd255, 32'd0, 32'd0);
    saturate(MODE_POLL);   // restart counter runs into its ceiling
    run_random(100);

    set_profile(49, 18);
    configure(8'd255, 8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    saturate(MODE_FAILED); // failure counter and backoff both saturate
    run_random(100);

    configure(CountW'($urandom_range(1, 4)), CountW'($urandom_range(0, 3)),
              TimeW'($urandom_range(1, 4000)), TimeW'($urandom_range(0, 100000)));
    run_random(100);

    set_profile(0, 0);
    configure(8'd1, 8'd1, 32'h6000_0000, 32'hFFFF_FFFF);
    run_random(100);

    configure(8'd2, 8'd3, 32'd250, 32'd5000);
    run_random(100);

    wait_idle();
    repeat (10) @(posedge clk_i);

    $display("run covered %0d events over six threshold settings, %0d results checked",
             events_sent, checked);
    $display("restarts predicted %0d, reboots predicted %0d, mismatches %0d",
             restarts_seen, reboots_seen, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
